### src/sdq_pkg.sv
package sdq_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned KEY_WIDTH = 32;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_FIELD_W = 5;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_SORT  = 3'd2,
    KIND_REM_FRONT = 3'd3,
    KIND_REM_BACK  = 3'd4,
    KIND_ROT_FWD   = 3'd5,
    KIND_ROT_BACK  = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_INS_TAIL,
    CELL_INS_SORT,
    CELL_ROT_FWD
  } cell_op_e;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [KEY_FIELD_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [KEY_FIELD_W-1:0]   removed_key;
    logic [KEY_FIELD_W-1:0]   front_key;
    logic [KEY_FIELD_W-1:0]   back_key;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic                     is_empty;
  } out_item_t;

  typedef struct packed {
    cell_op_e             op;
    logic [KEY_WIDTH-1:0] key;
    logic [KEY_WIDTH-1:0] front;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic is_last;
    logic is_tail;
  } cell_sel_t;

  typedef struct packed {
    logic passed;
    logic after;
  } cell_chain_t;

endpackage

### src/sdq_cell.sv
module sdq_cell (
  input  logic                            clk_i,
  input  sdq_pkg::cell_cmd_t              cmd_i,
  input  sdq_pkg::cell_sel_t              sel_i,
  input  sdq_pkg::cell_chain_t            chain_i,
  output sdq_pkg::cell_chain_t            chain_o,
  input  logic [sdq_pkg::KEY_WIDTH-1:0]   left_key_i,
  input  logic [sdq_pkg::KEY_WIDTH-1:0]   right_key_i,
  output logic [sdq_pkg::KEY_WIDTH-1:0]   key_o,
  output logic                            at_pos_o
);

  logic [sdq_pkg::KEY_WIDTH-1:0] key_q, key_d;
  logic                          beyond;

  // new key lands here when every earlier stored key is smaller
  assign beyond         = sel_i.valid && (cmd_i.key > key_q);
  assign at_pos_o       = chain_i.passed && !beyond;
  assign chain_o.passed = chain_i.passed && beyond;
  assign chain_o.after  = chain_i.after || at_pos_o;
  assign key_o          = key_q;

  always_comb begin
    key_d = key_q;
    case (cmd_i.op)
      sdq_pkg::CELL_SHIFT_IN:  key_d = left_key_i;
      sdq_pkg::CELL_SHIFT_OUT: key_d = right_key_i;
      sdq_pkg::CELL_INS_TAIL: begin
        if (sel_i.is_tail) key_d = cmd_i.key;
      end
      sdq_pkg::CELL_INS_SORT: begin
        if (at_pos_o) begin
          key_d = cmd_i.key;
        end else if (chain_i.after) begin
          key_d = left_key_i;
        end
      end
      sdq_pkg::CELL_ROT_FWD: key_d = sel_i.is_last ? cmd_i.front : right_key_i;
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

### src/sorted_circular_deque_unit.sv
// A result beat is registered; it appears in the cycle after acceptance.
// Throughput: one operation per cycle unless stalled; every operation
// finishes in one row update; per-cell compares find the sorted position.
// Reset: entry count, back key and output valid clear; stored keys keep
// whatever they hold and are never read until written.
module sorted_circular_deque_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sdq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdq_pkg::out_item_t out_data_o
);

  localparam int unsigned Cap  = sdq_pkg::CAPACITY;
  localparam int unsigned KeyW = sdq_pkg::KEY_WIDTH;
  localparam int unsigned CntW = sdq_pkg::CNT_W;
  localparam int unsigned FldW = sdq_pkg::KEY_FIELD_W;

  logic                accept;
  logic [KeyW-1:0]     key_in;
  logic [CntW-1:0]     count_q, count_d, count_m2;
  logic [KeyW-1:0]     back_q, back_d;
  logic [KeyW-1:0]     front_cur, front_d, removed_d, key_m2, left0;
  logic                empty, full, one, tail_hit;
  sdq_pkg::status_e    status_d;
  sdq_pkg::cell_cmd_t  cmd;
  logic                out_valid_q, out_valid_d;
  sdq_pkg::out_item_t  out_q;

  logic [KeyW-1:0]      cell_key [Cap];
  logic                 cell_at  [Cap];
  sdq_pkg::cell_sel_t   cell_sel [Cap];
  sdq_pkg::cell_chain_t chain    [Cap+1];

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign key_in      = KeyW'(in_data_i.key);
  assign empty       = (count_q == '0);
  assign full        = (count_q == CntW'(Cap));
  assign one         = (count_q == CntW'(1));
  assign count_m2    = count_q - CntW'(2);
  assign front_cur   = empty ? '0 : cell_key[0];
  assign chain[0]    = '{passed: 1'b1, after: 1'b0};

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic [KeyW-1:0] left_key, right_key;

    assign cell_sel[i].valid   = (CntW'(i) < count_q);
    assign cell_sel[i].is_last = (CntW'(i + 1) == count_q);
    assign cell_sel[i].is_tail = (CntW'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_key = left0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
    end

    if (i == Cap - 1) begin : g_end
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    sdq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .sel_i       (cell_sel[i]),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .at_pos_o    (cell_at[i])
    );
  end

  // key next to the back, and whether a sorted insert lands at the tail
  always_comb begin
    key_m2   = '0;
    tail_hit = 1'b0;
    for (int i = 0; i < Cap; i++) begin
      if (CntW'(i) == count_m2) key_m2 = key_m2 | cell_key[i];
      if (cell_at[i] && cell_sel[i].is_tail) tail_hit = 1'b1;
    end
  end

  always_comb begin
    status_d  = sdq_pkg::ST_DONE;
    removed_d = '0;
    front_d   = front_cur;
    back_d    = back_q;
    count_d   = count_q;
    left0     = key_in;
    cmd.op    = sdq_pkg::CELL_HOLD;
    cmd.key   = key_in;
    cmd.front = cell_key[0];
    if (accept) begin
      case (in_data_i.kind)
        sdq_pkg::KIND_INS_FRONT,
        sdq_pkg::KIND_INS_BACK,
        sdq_pkg::KIND_INS_SORT: begin
          if (full) begin
            status_d = sdq_pkg::ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
            if (in_data_i.kind == sdq_pkg::KIND_INS_FRONT) begin
              cmd.op  = sdq_pkg::CELL_SHIFT_IN;
              front_d = key_in;
              back_d  = empty ? key_in : back_q;
            end else if (in_data_i.kind == sdq_pkg::KIND_INS_BACK) begin
              cmd.op  = sdq_pkg::CELL_INS_TAIL;
              front_d = empty ? key_in : front_cur;
              back_d  = key_in;
            end else begin
              cmd.op  = sdq_pkg::CELL_INS_SORT;
              front_d = cell_at[0] ? key_in : front_cur;
              back_d  = tail_hit ? key_in : back_q;
            end
          end
        end
        sdq_pkg::KIND_REM_FRONT: begin
          if (empty) begin
            status_d = sdq_pkg::ST_EMPTY;
          end else begin
            cmd.op    = sdq_pkg::CELL_SHIFT_OUT;
            removed_d = front_cur;
            front_d   = one ? '0 : cell_key[1];
            back_d    = one ? '0 : back_q;
            count_d   = count_q - CntW'(1);
          end
        end
        sdq_pkg::KIND_REM_BACK: begin
          if (empty) begin
            status_d = sdq_pkg::ST_EMPTY;
          end else begin
            removed_d = back_q;
            front_d   = one ? '0 : front_cur;
            back_d    = one ? '0 : key_m2;
            count_d   = count_q - CntW'(1);
          end
        end
        sdq_pkg::KIND_ROT_FWD: begin
          if (empty) begin
            status_d = sdq_pkg::ST_EMPTY;
          end else begin
            cmd.op  = sdq_pkg::CELL_ROT_FWD;
            front_d = one ? front_cur : cell_key[1];
            back_d  = front_cur;
          end
        end
        sdq_pkg::KIND_ROT_BACK: begin
          if (empty) begin
            status_d = sdq_pkg::ST_EMPTY;
          end else begin
            cmd.op  = sdq_pkg::CELL_SHIFT_IN;
            left0   = back_q;
            front_d = back_q;
            back_d  = one ? back_q : key_m2;
          end
        end
        default: ;
      endcase
    end
  end

  // hold the result beat while stalled, load a fresh one on accept
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      back_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      back_q      <= back_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.status      <= status_d;
      out_q.removed_key <= FldW'(removed_d);
      out_q.front_key   <= FldW'(front_d);
      out_q.back_key    <= FldW'(back_d);
      out_q.entry_count <= sdq_pkg::COUNT_FIELD_W'(count_d);
      out_q.is_empty    <= (count_d == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Cap))
    else $error("entry count above capacity");

  a_full_insert_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (in_data_i.kind == sdq_pkg::KIND_INS_FRONT ||
      in_data_i.kind == sdq_pkg::KIND_INS_BACK ||
      in_data_i.kind == sdq_pkg::KIND_INS_SORT)) |=> $stable(count_q))
    else $error("insert into full store changed the count");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_empty) |->
      (out_data_o.front_key == '0 && out_data_o.back_key == '0))
    else $error("empty store reports a key");

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // kind code with no operation behind it
  localparam logic [sdq_pkg::KIND_W-1:0] KIND_NONE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  sdq_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sdq_pkg::out_item_t out_data_o;

  logic [sdq_pkg::KEY_FIELD_W-1:0] model_keys[$];
  sdq_pkg::out_item_t              pending_results[$];
  int unsigned                     fail_count = 0;
  int unsigned                     cycle_count = 0;
  bit                              idle_en = 1'b1;

  sorted_circular_deque_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the model deque and return the state it leaves.
  function automatic sdq_pkg::out_item_t apply_deque_op(sdq_pkg::in_item_t op);
    sdq_pkg::out_item_t              r;
    int unsigned                     pos;
    logic [sdq_pkg::KEY_FIELD_W-1:0] k;
    r = '0;
    r.status = sdq_pkg::ST_DONE;
    case (op.kind)
      sdq_pkg::KIND_INS_FRONT, sdq_pkg::KIND_INS_BACK, sdq_pkg::KIND_INS_SORT: begin
        if (model_keys.size() >= sdq_pkg::CAPACITY) begin
          r.status = sdq_pkg::ST_FULL;
        end else if (op.kind == sdq_pkg::KIND_INS_FRONT) begin
          model_keys.push_front(op.key);
        end else if (op.kind == sdq_pkg::KIND_INS_BACK) begin
          model_keys.push_back(op.key);
        end else begin
          // ties land before equal keys
          pos = 0;
          while (pos < model_keys.size() && op.key > model_keys[pos]) pos++;
          model_keys.insert(pos, op.key);
        end
      end
      sdq_pkg::KIND_REM_FRONT, sdq_pkg::KIND_REM_BACK, sdq_pkg::KIND_ROT_FWD,
      sdq_pkg::KIND_ROT_BACK: begin
        if (model_keys.size() == 0) begin
          r.status = sdq_pkg::ST_EMPTY;
        end else if (op.kind == sdq_pkg::KIND_REM_FRONT) begin
          r.removed_key = model_keys.pop_front();
        end else if (op.kind == sdq_pkg::KIND_REM_BACK) begin
          r.removed_key = model_keys.pop_back();
        end else if (op.kind == sdq_pkg::KIND_ROT_FWD) begin
          k = model_keys.pop_front();
          model_keys.push_back(k);
        end else begin
          k = model_keys.pop_back();
          model_keys.push_front(k);
        end
      end
      default: ;
    endcase
    if (model_keys.size() != 0) begin
      r.front_key = model_keys[0];
      r.back_key  = model_keys[model_keys.size() - 1];
    end
    r.entry_count = sdq_pkg::COUNT_FIELD_W'(model_keys.size());
    r.is_empty    = (model_keys.size() == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [sdq_pkg::KEY_FIELD_W-1:0] exp_v,
                                      logic [sdq_pkg::KEY_FIELD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    sdq_pkg::out_item_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pending_results.push_back(apply_deque_op(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no operation outstanding");
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("status", sdq_pkg::KEY_FIELD_W'(exp_r.status),
                      sdq_pkg::KEY_FIELD_W'(out_data_o.status));
          check_field("removed_key", exp_r.removed_key, out_data_o.removed_key);
          check_field("front_key", exp_r.front_key, out_data_o.front_key);
          check_field("back_key", exp_r.back_key, out_data_o.back_key);
          check_field("entry_count", sdq_pkg::KEY_FIELD_W'(exp_r.entry_count),
                      sdq_pkg::KEY_FIELD_W'(out_data_o.entry_count));
          check_field("is_empty", sdq_pkg::KEY_FIELD_W'(exp_r.is_empty),
                      sdq_pkg::KEY_FIELD_W'(out_data_o.is_empty));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_circular_deque_unit] ERROR");
      $finish;
    end
  end

  // Present one beat and hold it until it is taken.
  task automatic push_op(input logic [sdq_pkg::KIND_W-1:0] kind,
                         input logic [sdq_pkg::KEY_FIELD_W-1:0] key);
    sdq_pkg::in_item_t item;
    item.kind = kind;
    item.key  = key;
    if (idle_en && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Favour small keys and keys near the top so that ties and extremes turn up.
  function automatic logic [sdq_pkg::KEY_FIELD_W-1:0] draw_key();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_store();
    push_op(sdq_pkg::KIND_REM_FRONT, 32'hFFFF_FFFF);
    push_op(sdq_pkg::KIND_REM_BACK, 32'h0);
    push_op(sdq_pkg::KIND_ROT_FWD, 32'h5555_5555);
    push_op(sdq_pkg::KIND_ROT_BACK, 32'hAAAA_AAAA);
    push_op(KIND_NONE, 32'h1234_5678);
  endtask

  task automatic test_end_keys();
    push_op(sdq_pkg::KIND_INS_SORT, 32'h8000_0000);
    push_op(sdq_pkg::KIND_INS_FRONT, 32'hFFFF_FFFF);
    push_op(sdq_pkg::KIND_INS_BACK, 32'h0);
    push_op(sdq_pkg::KIND_INS_SORT, 32'h8000_0000);
    push_op(sdq_pkg::KIND_INS_SORT, 32'h0);
    push_op(sdq_pkg::KIND_INS_SORT, 32'hFFFF_FFFF);
    push_op(KIND_NONE, 32'hFFFF_FFFF);
    push_op(sdq_pkg::KIND_ROT_FWD, 32'h0);
    push_op(sdq_pkg::KIND_ROT_BACK, 32'h0);
    push_op(sdq_pkg::KIND_REM_FRONT, 32'h0);
    push_op(sdq_pkg::KIND_REM_BACK, 32'h0);
    while (model_keys.size() != 0 || pending_results.size() != 0) begin
      if (model_keys.size() != 0) begin
        push_op(sdq_pkg::KIND_REM_FRONT, 32'h0);
      end else begin
        // drop valid so the last beat is not taken again
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    // a lone key inserted at the front of an empty store
    push_op(sdq_pkg::KIND_INS_FRONT, 32'h7FFF_FFFF);
    push_op(sdq_pkg::KIND_REM_BACK, 32'h0);
    push_op(sdq_pkg::KIND_INS_BACK, 32'h0000_0001);
    push_op(sdq_pkg::KIND_REM_FRONT, 32'h0);
  endtask

  task automatic test_capacity_edges();
    int unsigned i;
    for (i = 0; i < sdq_pkg::CAPACITY; i++) push_op(3'(i % 3), draw_key());
    push_op(sdq_pkg::KIND_INS_FRONT, $urandom);
    push_op(sdq_pkg::KIND_INS_BACK, $urandom);
    push_op(sdq_pkg::KIND_INS_SORT, $urandom);
    push_op(sdq_pkg::KIND_ROT_FWD, $urandom);
    push_op(sdq_pkg::KIND_ROT_BACK, $urandom);
    for (i = 0; i <= sdq_pkg::CAPACITY; i++)
      push_op(i[0] ? sdq_pkg::KIND_REM_BACK : sdq_pkg::KIND_REM_FRONT, $urandom);
  endtask

  task automatic test_mixed_traffic();
    int unsigned  round_n;
    int unsigned  i;
    int unsigned  roll;
    int unsigned  ins_lim;
    int unsigned  rem_lim;
    logic [sdq_pkg::KIND_W-1:0] kind;
    for (round_n = 0; round_n < 18; round_n++) begin
      idle_en = (round_n != 5);
      // alternate between filling towards full and draining towards empty
      ins_lim = round_n[0] ? 25 : 60;
      rem_lim = round_n[0] ? 80 : 85;
      for (i = 0; i < 100; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_lim) kind = 3'($urandom_range(0, 2));
        else if (roll < rem_lim) kind = 3'($urandom_range(3, 4));
        else if (roll < 99) kind = 3'($urandom_range(5, 6));
        else kind = KIND_NONE;
        push_op(kind, draw_key());
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_end_keys();
    test_capacity_edges();
    test_mixed_traffic();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[sorted_circular_deque_unit] OK");
    end else begin
      $display("[sorted_circular_deque_unit] ERROR");
    end
    $finish;
  end

endmodule
